[design/slt_pkg.sv]
package slt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W     = 16;
  localparam int AMT_W     = 16;
  localparam int QTY_W     = 24;
  localparam int LOT_CNT_W = 5;
  localparam int STATUS_W  = 3;

  localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_MERGED    = 3'd0,
    STAT_NEW       = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DECREASED = 3'd3,
    STAT_DELETED   = 3'd4,
    STAT_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_SHIFT_UP,
    ST_SHIFT_DOWN,
    ST_WRITE_NEW,
    ST_EMIT
  } slt_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [QTY_W-1:0] qty;
  } lot_entry_t;

  typedef struct packed {
    logic [QTY_W-1:0]     remaining;
    logic [LOT_CNT_W-1:0] lot_count;
    status_t              status;
  } result_t;

endpackage

[design/sorted_lot_table_unit.sv]
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tuser: req_type; tdata: amount, expiry_key
// out_     out  out_tvalid/out_tready tdata: status, lot_count, remaining
//
// One item at a time: accept, key search (one RAM read per cycle), decide, entry
// moves (one per cycle), a write of the new lot for an insert that moved entries,
// then the result. The single read port of the lot RAM sets this pace.
// Synchronous active-low reset empties the table (lot count to zero); RAM contents
// are left as they are. A new item is taken while a result still waits in the
// output register; an item that finishes then holds until that register frees.
module sorted_lot_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] amount, [31:16] expiry_key
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [2:0] status, [7:3] lot_count, [31:8] remaining
);
  import slt_pkg::*;

  slt_state_t state_r, state_nxt;

  // request being worked on
  req_t             req_r, req_nxt;
  logic [AMT_W-1:0] amt_r, amt_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;  // lots held
  logic [CNT_W-1:0] idx_r, idx_nxt;      // scan / shift pointer
  logic [CNT_W-1:0] pos_r, pos_nxt;      // sorted slot of the key
  logic             hit_r, hit_nxt;
  logic [QTY_W-1:0] held_r, held_nxt;    // quantity at the hit slot

  status_t          res_status_r, res_status_nxt;
  logic [QTY_W-1:0] res_remain_r, res_remain_nxt;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;

  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  lot_entry_t       ram_wdata, ram_rdata;

  logic [QTY_W:0]   sum_full;
  logic [QTY_W-1:0] sum_sat;
  logic [QTY_W-1:0] amt_ext;
  logic             in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign amt_ext  = QTY_W'(amt_r);
  assign sum_full = {1'b0, held_r} + {1'b0, amt_ext};
  assign sum_sat  = sum_full[QTY_W] ? QTY_MAX : sum_full[QTY_W-1:0];

  slt_ram #(
    .WIDTH($bits(lot_entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_lot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    amt_r        <= amt_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    hit_r        <= hit_nxt;
    held_r       <= held_nxt;
    res_status_r <= res_status_nxt;
    res_remain_r <= res_remain_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    amt_nxt        = amt_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    held_nxt       = held_r;
    res_status_nxt = res_status_r;
    res_remain_nxt = res_remain_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt = req_t'(in_tuser[0]);
          amt_nxt = in_tdata[AMT_W-1:0];
          key_nxt = in_tdata[AMT_W +: KEY_W];
          idx_nxt = '0;
          if (count_r == '0) begin
            pos_nxt   = '0;
            hit_nxt   = 1'b0;
            state_nxt = ST_DECIDE;
          end else begin
            ram_raddr = '0;
            state_nxt = ST_SEARCH;
          end
        end
      end

      // read data belongs to entry idx_r
      ST_SEARCH: begin
        if (ram_rdata.key < key_r) begin
          if (idx_r + CNT_W'(1) == count_r) begin
            pos_nxt   = count_r;
            hit_nxt   = 1'b0;
            state_nxt = ST_DECIDE;
          end else begin
            ram_raddr = ADDR_W'(idx_r + CNT_W'(1));
            idx_nxt   = idx_r + CNT_W'(1);
          end
        end else begin
          pos_nxt   = idx_r;
          hit_nxt   = (ram_rdata.key == key_r);
          held_nxt  = ram_rdata.qty;
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (req_r == REQ_INSERT) begin
          if (hit_r) begin
            ram_we         = 1'b1;
            ram_waddr      = ADDR_W'(pos_r);
            ram_wdata      = '{key: key_r, qty: sum_sat};
            res_status_nxt = STAT_MERGED;
            res_remain_nxt = sum_sat;
            state_nxt      = ST_EMIT;
          end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
            res_status_nxt = STAT_FULL;
            res_remain_nxt = '0;
            state_nxt      = ST_EMIT;
          end else if (count_r == pos_r) begin
            ram_we         = 1'b1;
            ram_waddr      = ADDR_W'(pos_r);
            ram_wdata      = '{key: key_r, qty: amt_ext};
            count_nxt      = count_r + CNT_W'(1);
            res_status_nxt = STAT_NEW;
            res_remain_nxt = amt_ext;
            state_nxt      = ST_EMIT;
          end else begin
            // move entries pos..count-1 up by one, from the top down
            ram_raddr = ADDR_W'(count_r - CNT_W'(1));
            idx_nxt   = count_r;
            state_nxt = ST_SHIFT_UP;
          end
        end else begin
          if (!hit_r) begin
            res_status_nxt = STAT_NOT_FOUND;
            res_remain_nxt = '0;
            state_nxt      = ST_EMIT;
          end else if (amt_ext < held_r) begin
            ram_we         = 1'b1;
            ram_waddr      = ADDR_W'(pos_r);
            ram_wdata      = '{key: key_r, qty: held_r - amt_ext};
            res_status_nxt = STAT_DECREASED;
            res_remain_nxt = held_r - amt_ext;
            state_nxt      = ST_EMIT;
          end else if (pos_r + CNT_W'(1) == count_r) begin
            count_nxt      = count_r - CNT_W'(1);
            res_status_nxt = STAT_DELETED;
            res_remain_nxt = '0;
            state_nxt      = ST_EMIT;
          end else begin
            // close the gap: entries above pos move down by one
            ram_raddr = ADDR_W'(pos_r + CNT_W'(1));
            idx_nxt   = pos_r;
            state_nxt = ST_SHIFT_DOWN;
          end
        end
      end

      // write idx_r with entry idx_r-1, read of idx_r-2 overlaps
      ST_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(idx_r);
        ram_wdata = ram_rdata;
        if (idx_r - CNT_W'(1) == pos_r) begin
          state_nxt = ST_WRITE_NEW;
        end else begin
          ram_raddr = ADDR_W'(idx_r - CNT_W'(2));
          idx_nxt   = idx_r - CNT_W'(1);
        end
      end

      ST_WRITE_NEW: begin
        ram_we         = 1'b1;
        ram_waddr      = ADDR_W'(pos_r);
        ram_wdata      = '{key: key_r, qty: amt_ext};
        count_nxt      = count_r + CNT_W'(1);
        res_status_nxt = STAT_NEW;
        res_remain_nxt = amt_ext;
        state_nxt      = ST_EMIT;
      end

      // write idx_r with entry idx_r+1, read of idx_r+2 overlaps
      ST_SHIFT_DOWN: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(idx_r);
        ram_wdata = ram_rdata;
        if (idx_r + CNT_W'(2) == count_r) begin
          count_nxt      = count_r - CNT_W'(1);
          res_status_nxt = STAT_DELETED;
          res_remain_nxt = '0;
          state_nxt      = ST_EMIT;
        end else begin
          ram_raddr = ADDR_W'(idx_r + CNT_W'(2));
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = res_status_r;
          out_data_nxt.lot_count = LOT_CNT_W'(count_r);
          out_data_nxt.remaining = res_remain_r;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/slt_ram.sv]
module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/slt_checker.sv]
module slt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import slt_pkg::*;

  result_t res;
  assign res = out_tdata;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.status <= STAT_NOT_FOUND)
    else $error("status code out of range");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.status == STAT_FULL |-> res.lot_count == LOT_CNT_W'(TABLE_DEPTH))
    else $error("full reported with room left");

  a_zero_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.status == STAT_FULL || res.status == STAT_DELETED ||
                   res.status == STAT_NOT_FOUND) |-> res.remaining == '0)
    else $error("quantity reported for absent lot");

  a_new_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.status == STAT_NEW || res.status == STAT_MERGED) |->
      res.lot_count != '0)
    else $error("lot present but table empty");

endmodule

bind sorted_lot_table_unit slt_checker u_slt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

[test/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int IDLE_LIMIT = 5000;  // cycles with no accepted item on either side
  localparam int TAIL_CYCLES = 60;   // settle time after the last result

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;     // [15:0] amount, [31:16] expiry_key
  logic [0:0]  in_tuser   = '0;     // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [31:0] out_tdata;           // [2:0] status, [7:3] lot_count, [31:8] remaining

  sorted_lot_table_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the lot table, updated once per accepted item.
  logic [KEY_W-1:0] lot_key_copy [TABLE_DEPTH];
  logic [QTY_W-1:0] lot_qty_copy [TABLE_DEPTH];
  int               lots_in_copy = 0;

  result_t pending_results[$];   // expected results, oldest first
  int      errors       = 0;
  int      sent_count   = 0;
  int      status_seen [6];
  bit      steady_flow  = 1'b0;  // when set neither side idles
  int      idle_cycles  = 0;
  int      rx_hold      = 0;

  // ---------------------------------------------------------------------------
  // Lot table predictor: applies one request to the shadow table and returns
  // the result the block should produce for it.
  // ---------------------------------------------------------------------------
  task automatic apply_lot_request(input req_t req, input logic [AMT_W-1:0] amt,
                                   input logic [KEY_W-1:0] key, output result_t res);
    int          pos;
    int          i;
    bit          hit;
    logic [QTY_W:0] sum;
    pos = 0;
    while (pos < lots_in_copy && lot_key_copy[pos] < key) pos++;
    hit = (pos < lots_in_copy) && (lot_key_copy[pos] == key);
    res.remaining = '0;
    if (req == REQ_INSERT) begin
      if (hit) begin
        // merge, saturating at the quantity ceiling
        sum = lot_qty_copy[pos] + amt;
        if (sum > QTY_MAX) sum = QTY_MAX;
        lot_qty_copy[pos] = sum[QTY_W-1:0];
        res.remaining = sum[QTY_W-1:0];
        res.status = STAT_MERGED;
      end else if (lots_in_copy >= TABLE_DEPTH) begin
        res.status = STAT_FULL;          // table unchanged
      end else begin
        for (i = lots_in_copy; i > pos; i--) begin
          lot_key_copy[i] = lot_key_copy[i-1];
          lot_qty_copy[i] = lot_qty_copy[i-1];
        end
        lot_key_copy[pos] = key;
        lot_qty_copy[pos] = QTY_W'(amt);
        lots_in_copy++;
        res.remaining = QTY_W'(amt);
        res.status = STAT_NEW;
      end
    end else begin
      if (!hit) begin
        res.status = STAT_NOT_FOUND;
      end else if (QTY_W'(amt) < lot_qty_copy[pos]) begin
        lot_qty_copy[pos] = lot_qty_copy[pos] - amt;
        res.remaining = lot_qty_copy[pos];
        res.status = STAT_DECREASED;
      end else begin
        // removal covers the whole lot: close the gap
        for (i = pos; i + 1 < lots_in_copy; i++) begin
          lot_key_copy[i] = lot_key_copy[i+1];
          lot_qty_copy[i] = lot_qty_copy[i+1];
        end
        lots_in_copy--;
        res.status = STAT_DELETED;
      end
    end
    res.lot_count = LOT_CNT_W'(lots_in_copy);
  endtask

  function automatic bit key_is_held(logic [KEY_W-1:0] key);
    for (int i = 0; i < lots_in_copy; i++)
      if (lot_key_copy[i] == key) return 1'b1;
    return 1'b0;
  endfunction

  // Sender gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Send one request item; the expectation is recorded at the accepting edge.
  // tvalid stays high across back-to-back items.
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_t req, input logic [AMT_W-1:0] amt,
                              input logic [KEY_W-1:0] key);
    int      gap;
    result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {key, amt};
    do @(posedge clk); while (!in_tready);
    apply_lot_request(req, amt, key, res);
    pending_results.push_back(res);
    sent_count++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: random stalls, short most of the time, now and then long.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    int roll;
    if (!rst_n || steady_flow) begin
      out_tready <= 1'b1;
      rx_hold    <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_hold    <= (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got 0x%08h", $time, out_tdata);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("status", exp_res.status, out_tdata[2:0]);
        compare_field("lot_count", exp_res.lot_count, out_tdata[7:3]);
        compare_field("remaining", exp_res.remaining, out_tdata[31:8]);
        if (out_tdata[2:0] <= STAT_NOT_FOUND) status_seen[out_tdata[2:0]]++;
      end
    end
  end

  // Watchdog: a long stretch with no item moving on either side means a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending_results.size());
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of key and amount, ordering at head, middle and tail, zero amounts.
  task automatic test_directed();
    send_request(REQ_REMOVE, 16'd5,      16'h0005);  // empty table: not found
    send_request(REQ_INSERT, 16'd0,      16'h8000);  // new lot holding zero
    send_request(REQ_REMOVE, 16'd0,      16'h8000);  // zero removal deletes empty lot
    send_request(REQ_INSERT, 16'd100,    16'h8000);
    send_request(REQ_INSERT, 16'hFFFF,   16'h0000);  // lands at head
    send_request(REQ_INSERT, 16'd1,      16'hFFFF);  // lands at tail
    send_request(REQ_INSERT, 16'd7,      16'h4000);  // lands in the middle
    send_request(REQ_INSERT, 16'hFFFF,   16'h8000);  // merge
    send_request(REQ_INSERT, 16'd0,      16'h4000);  // zero merge, no change
    send_request(REQ_REMOVE, 16'd0,      16'h8000);  // zero removal, decreased
    send_request(REQ_REMOVE, 16'hFFFF,   16'h8000);  // decreased back to 100
    send_request(REQ_REMOVE, 16'd100,    16'h8000);  // exact amount deletes
    send_request(REQ_REMOVE, 16'd1,      16'h7FFF);  // missing key between lots
    send_request(REQ_INSERT, 16'h8000,   16'hAAAA);
    send_request(REQ_INSERT, 16'h5555,   16'h5555);
    send_request(REQ_REMOVE, 16'hFFFF,   16'h0000);  // head deleted
    send_request(REQ_REMOVE, 16'd5,      16'hFFFF);  // tail deleted, more than held
    send_request(REQ_REMOVE, 16'h7FFF,   16'hAAAA);  // decreased to 1
  endtask

  // Fill the table, then a new key is dropped while existing keys still work.
  task automatic test_full_table();
    logic [KEY_W-1:0] key;
    while (lots_in_copy < TABLE_DEPTH)
      send_request(REQ_INSERT, AMT_W'($urandom_range(1, 500)), KEY_W'($urandom));
    do key = KEY_W'($urandom); while (key_is_held(key));
    send_request(REQ_INSERT, 16'd9,    key);                 // full: dropped
    send_request(REQ_INSERT, 16'd9,    lot_key_copy[5]);     // merge still allowed
    send_request(REQ_REMOVE, 16'd1,    key);                 // not found
    send_request(REQ_REMOVE, 16'hFFFF, lot_key_copy[0]);     // delete head
    send_request(REQ_INSERT, 16'd3,    key);                 // refill
    send_request(REQ_INSERT, 16'd3,    ~key);                // full again, most likely
    send_request(REQ_REMOVE, 16'hFFFF, lot_key_copy[TABLE_DEPTH-1]);  // delete tail
    send_request(REQ_REMOVE, 16'd1,    lot_key_copy[7]);
  endtask

  // Mixed traffic on a small key pool so that hits, fills and drops all recur.
  task automatic test_random(input int n_items);
    logic [KEY_W-1:0] key_pool [24];
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amt;
    logic [QTY_W-1:0] held_qty;
    int               insert_pct;
    int               roll;
    int               idx;
    bit               from_table;
    insert_pct = 50;
    for (int k = 0; k < n_items; k++) begin
      if (k % 200 == 0) begin
        // new key pool; some keys clustered, some spread over the full range
        for (int p = 0; p < 24; p++)
          key_pool[p] = (p < 8) ? KEY_W'($urandom_range(0, 40)) + 16'h7FE0 : KEY_W'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        case ($urandom_range(0, 2))
          0:       insert_pct = 30;
          1:       insert_pct = 50;
          default: insert_pct = 70;
        endcase
      end
      if (k % 100 == 0) steady_flow = ($urandom_range(0, 3) == 0);

      from_table = 1'b0;
      held_qty   = '0;
      roll = $urandom_range(0, 99);
      if (roll < 25 && lots_in_copy > 0) begin
        idx        = $urandom_range(0, lots_in_copy - 1);
        key        = lot_key_copy[idx];
        held_qty   = lot_qty_copy[idx];
        from_table = 1'b1;
      end else if (roll < 90) begin
        key = key_pool[$urandom_range(0, 23)];
      end else begin
        key = KEY_W'($urandom);
      end

      roll = $urandom_range(0, 99);
      if (roll < 40)      amt = AMT_W'($urandom_range(1, 20));
      else if (roll < 60) amt = AMT_W'($urandom_range(1, 1000));
      else if (roll < 85) amt = AMT_W'($urandom);
      else if (roll < 90) amt = '0;
      else if (roll < 95) amt = '1;
      else amt = (from_table && held_qty <= 24'hFFFF) ? held_qty[AMT_W-1:0] : AMT_W'(1);

      send_request(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE, amt, key);
    end
    steady_flow = 1'b0;
  endtask

  // Drive one lot to the quantity ceiling and past it, then draw it down.
  task automatic test_saturation();
    logic [KEY_W-1:0] key;
    key = (lots_in_copy > 0) ? lot_key_copy[0] : 16'h1234;
    repeat (258) send_request(REQ_INSERT, 16'hFFFF, key);
    send_request(REQ_INSERT, 16'd1,    key);   // already at the ceiling
    send_request(REQ_REMOVE, 16'd0,    key);
    send_request(REQ_REMOVE, 16'hFFFF, key);
    send_request(REQ_INSERT, 16'hFFFF, key);   // back to the ceiling exactly
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_table();
    test_random(700);
    test_saturation();
    stop_sending();

    while (pending_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests incl. full-table drops and quantity saturation.", sent_count);
    $display("Results: merged %0d, new %0d, full %0d, decreased %0d, deleted %0d, missing %0d",
             status_seen[STAT_MERGED], status_seen[STAT_NEW], status_seen[STAT_FULL],
             status_seen[STAT_DECREASED], status_seen[STAT_DELETED],
             status_seen[STAT_NOT_FOUND]);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
